/* design/assert_macros.svh */
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define TCCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define TCCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/tccs_pkg.sv */
package tccs_pkg;

   // Command codes of a request.
   localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
   localparam logic [1:0] CMD_PUT_HEX  = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   // Character codes with a meaning of their own.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_HEX_A = 8'h41 - 8'd10;

   localparam logic [3:0] NIBBLE_MAX     = 4'd9;
   localparam int         TAB_STEP       = 4;
   localparam logic [3:0] HEX_LAST_INDEX = 4'd9;
   localparam logic [7:0] ATTR_RESET     = 8'h0F;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [31:0] hex_value;
      logic [4:0]  read_row;
      logic [6:0]  read_col;
   } req_item_type;

   typedef struct packed {
      logic        echo_valid;
      logic [7:0]  echo_char;
      logic [15:0] cell_value;
      logic [4:0]  cursor_row_out;
      logic [6:0]  cursor_col_out;
      logic        last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_CHAR,
      OP_CLEAR,
      OP_READ
   } op_kind_type;

   // One unit of work for the back end: a single character, a clear or a read.
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_code;
      logic [4:0]  read_row;
      logic [6:0]  read_col;
      logic        last;
   } op_item_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'b0000, nibble};
      if (nibble <= NIBBLE_MAX) begin
         return wide + CHAR_ZERO;
      end
      return wide + CHAR_HEX_A;
   endfunction

endpackage

/* design/tccs_fifo.sv */
module tccs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/tccs_front.sv */
module tccs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   hold,
   input  logic                   req_push,
   input  tccs_pkg::req_item_type req_data,
   output logic                   req_full,
   input  logic                   op_full,
   output logic                   op_push,
   output tccs_pkg::op_item_type  op_data
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] hex_ff, hex_in;
   logic        accept;
   logic [7:0]  digit;

   assign req_full = busy_ff | op_full | hold;
   assign accept   = req_push & ~req_full;

   always_comb begin
      if (cnt_ff == 4'd0) begin
         digit = tccs_pkg::CHAR_ZERO;
      end else if (cnt_ff == 4'd1) begin
         digit = tccs_pkg::CHAR_X;
      end else begin
         digit = tccs_pkg::hex_char(hex_ff[31:28]);
      end
   end

   always_comb begin
      busy_in           = busy_ff;
      cnt_in            = cnt_ff;
      hex_in            = hex_ff;
      op_push           = 1'b0;
      op_data.kind      = tccs_pkg::OP_CHAR;
      op_data.char_code = req_data.char_code;
      op_data.read_row  = req_data.read_row;
      op_data.read_col  = req_data.read_col;
      op_data.last      = 1'b1;
      if (busy_ff) begin
         // Hex word expansion: one printed character per cycle while the work queue has room.
         op_data.char_code = digit;
         op_data.last      = (cnt_ff == tccs_pkg::HEX_LAST_INDEX);
         if (!op_full) begin
            op_push = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff >= 4'd2) begin
               hex_in = {hex_ff[27:0], 4'b0000};
            end
            if (cnt_ff == tccs_pkg::HEX_LAST_INDEX) begin
               busy_in = 1'b0;
            end
         end
      end else if (accept) begin
         case (req_data.cmd)
            tccs_pkg::CMD_PUT_CHAR: begin
               op_push = 1'b1;
            end
            tccs_pkg::CMD_PUT_HEX: begin
               busy_in = 1'b1;
               cnt_in  = '0;
               hex_in  = req_data.hex_value;
            end
            tccs_pkg::CMD_CLEAR: begin
               op_push      = 1'b1;
               op_data.kind = tccs_pkg::OP_CLEAR;
            end
            tccs_pkg::CMD_READ: begin
               op_push      = 1'b1;
               op_data.kind = tccs_pkg::OP_READ;
            end
            default: begin
               op_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff <= hex_in;
   end

endmodule

/* design/tccs_back.sv */
module tccs_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             attr,
   input  logic                   op_empty,
   input  tccs_pkg::op_item_type  op_data,
   output logic                   op_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output tccs_pkg::rsp_item_type rsp_data,
   output logic                   init_busy
);

   localparam int NUM_CELLS = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(NUM_CELLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_SCROLL_LAST,
      ST_FILL
   } state_type;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     waddr_ff, waddr_in;
   tccs_pkg::op_item_type op_ff, op_in;
   logic                  rd_ok_ff, rd_ok_in;

   logic [15:0]           mem [NUM_CELLS];
   logic [15:0]           rdata_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [15:0]           mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;

   logic [COL_W:0]        col_step;
   logic [ROW_W-1:0]      row_step;
   logic                  wr_char;
   logic                  scroll;
   logic [ADDR_W-1:0]     cur_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  rd_ok;

   assign init_busy = (state_ff == ST_INIT);
   assign cur_addr  = ADDR_W'(ADDR_W'(row_ff) * ROW_SPAN) + ADDR_W'(col_ff);
   assign rd_addr   = ADDR_W'(ADDR_W'(op_data.read_row) * ROW_SPAN)
                      + ADDR_W'(op_data.read_col);
   assign rd_ok     = (32'(op_data.read_row) < ROWS) && (32'(op_data.read_col) < COLUMNS);

   // Cursor update for one printed character.
   always_comb begin
      col_step = {1'b0, col_ff};
      row_step = row_ff;
      wr_char  = 1'b0;
      if (op_data.char_code == tccs_pkg::CHAR_LF) begin
         row_step = row_ff + 1'b1;
      end else if (op_data.char_code == tccs_pkg::CHAR_CR) begin
         col_step = '0;
      end else if (op_data.char_code == tccs_pkg::CHAR_TAB) begin
         col_step = {1'b0, col_ff} + (COL_W + 1)'(tccs_pkg::TAB_STEP);
      end else begin
         wr_char  = 1'b1;
         col_step = {1'b0, col_ff} + 1'b1;
      end
      if (col_step >= (COL_W + 1)'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + 1'b1;
      end
      scroll = (row_step >= ROW_W'(ROWS - 1));
      if (scroll) begin
         row_step = row_step - 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      addr_in   = addr_ff;
      pend_in   = pend_ff;
      waddr_in  = waddr_ff;
      op_in     = op_ff;
      rd_ok_in  = rd_ok_ff;
      op_pop    = 1'b0;
      rsp_push  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      mem_raddr = addr_ff;

      rsp_data.echo_valid     = (op_ff.kind == tccs_pkg::OP_CHAR);
      rsp_data.echo_char      = (op_ff.kind == tccs_pkg::OP_CHAR) ? op_ff.char_code : 8'h00;
      rsp_data.cell_value     = '0;
      rsp_data.cursor_row_out = 5'(row_ff);
      rsp_data.cursor_col_out = 7'(col_ff);
      rsp_data.last           = op_ff.last;

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!op_empty && !rsp_full) begin
               op_pop = 1'b1;
               op_in  = op_data;
               case (op_data.kind)
                  tccs_pkg::OP_CHAR: begin
                     mem_we    = wr_char;
                     mem_waddr = cur_addr;
                     mem_wdata = {attr, op_data.char_code};
                     row_in    = row_step;
                     col_in    = col_step[COL_W-1:0];
                     if (scroll) begin
                        addr_in  = ROW_SPAN;
                        pend_in  = 1'b0;
                        state_in = ST_SCROLL;
                     end else begin
                        rsp_push                = 1'b1;
                        rsp_data.echo_valid     = 1'b1;
                        rsp_data.echo_char      = op_data.char_code;
                        rsp_data.cursor_row_out = 5'(row_step);
                        rsp_data.cursor_col_out = 7'(col_step[COL_W-1:0]);
                        rsp_data.last           = op_data.last;
                     end
                  end
                  tccs_pkg::OP_CLEAR: begin
                     addr_in  = '0;
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_FILL;
                  end
                  tccs_pkg::OP_READ: begin
                     mem_raddr = rd_addr;
                     rd_ok_in  = rd_ok;
                     state_in  = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_push            = 1'b1;
            rsp_data.cell_value = rd_ok_ff ? rdata_ff : 16'h0000;
            state_in            = ST_IDLE;
         end
         ST_SCROLL: begin
            // Read one row ahead, write the word read last cycle one row up.
            mem_we    = pend_ff;
            mem_waddr = waddr_ff;
            mem_wdata = rdata_ff;
            pend_in   = 1'b1;
            waddr_in  = addr_ff - ROW_SPAN;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_SCROLL_LAST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_SCROLL_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = waddr_ff;
            mem_wdata = rdata_ff;
            rsp_push  = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = {attr, tccs_pkg::CHAR_SPACE};
            if (addr_ff == LAST_ADDR) begin
               rsp_push = 1'b1;
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         addr_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         addr_ff  <= addr_in;
         pend_ff  <= pend_in;
      end
      waddr_ff <= waddr_in;
      op_ff    <= op_in;
      rd_ok_ff <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

/* design/text_console_cursor_scroll.sv */
// Text console writer. The block holds a ROWS x COLUMNS screen of 16-bit
// cells (character in the low byte, attribute in the high byte) and a cursor.
// Requests go in through a queue-style port (req_push/req_full) and results
// come out the same way (rsp_empty/rsp_pop), oldest first. A put-character
// request gives one result, a hex word gives ten (the characters "0x" and
// eight uppercase digits, with last set on the tenth), and clear and read
// each give one. The attribute stored with written and cleared cells comes
// from the csr port, which is always ready and should be written only while
// the block is idle. Internally a front end decodes requests and expands hex
// words at one character per cycle, while there is room, into a four-entry
// work queue; a back end owns the screen memory (one write, one registered
// read port) and the cursor. An ordinary character is done in the idle
// state, and a read also passes through a read state for the registered
// word. A character that moves the cursor onto the last row scrolls the
// screen up by copying one cell per cycle through the memory port; a clear
// writes one cell per cycle over all ROWS*COLUMNS cells. After reset the
// back end zeroes the memory in one pass, during which req_full stays high.
`include "assert_macros.svh"

module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  tccs_pkg::req_item_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output tccs_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);

   localparam int OP_W      = $bits(tccs_pkg::op_item_type);
   localparam int RSP_W     = $bits(tccs_pkg::rsp_item_type);
   localparam int OPQ_DEPTH = 4;
   localparam int RSQ_DEPTH = 2;

   logic [7:0]             attr_ff;
   logic                   init_busy;

   // Front end to work queue.
   logic                   op_push;
   tccs_pkg::op_item_type  op_push_data;
   logic                   opq_full;

   // Work queue to back end.
   logic                   op_pop;
   logic [OP_W-1:0]        op_pop_bits;
   tccs_pkg::op_item_type  op_pop_data;
   logic                   opq_empty;

   // Back end to result queue.
   logic                   rsp_push;
   tccs_pkg::rsp_item_type rsp_push_data;
   logic                   rsq_full;
   logic [RSP_W-1:0]       rsp_pop_bits;

   // The attribute register takes every write in the cycle it is offered.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccs_pkg::ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   // The front end holds off requests while the screen memory is being
   // zeroed after reset.
   tccs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (init_busy),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_full  (opq_full),
      .op_push  (op_push),
      .op_data  (op_push_data)
   );

   tccs_fifo #(
      .WIDTH (OP_W),
      .DEPTH (OPQ_DEPTH)
   ) u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_push_data),
      .full      (opq_full),
      .pop       (op_pop),
      .pop_data  (op_pop_bits),
      .empty     (opq_empty)
   );

   assign op_pop_data = tccs_pkg::op_item_type'(op_pop_bits);

   // The back end only starts a piece of work when the result queue has
   // room, so the result it produces later always finds a free slot.
   tccs_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .op_empty  (opq_empty),
      .op_data   (op_pop_data),
      .op_pop    (op_pop),
      .rsp_full  (rsq_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data),
      .init_busy (init_busy)
   );

   // The result queue lets the back end move on while a result waits.
   tccs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSQ_DEPTH)
   ) u_rsq (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .full      (rsq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_pop_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = tccs_pkg::rsp_item_type'(rsp_pop_bits);

   // A result is never dropped: the back end never pushes into a full queue.
   `TCCS_ASSERT(a_rsq_no_overflow, clock, reset, !(rsp_push && rsq_full))

   // The front end never pushes work into a full queue.
   `TCCS_ASSERT(a_opq_no_overflow, clock, reset, !(op_push && opq_full))

   // The back end never takes work that is not there.
   `TCCS_ASSERT(a_opq_no_underflow, clock, reset, !(op_pop && opq_empty))

   // The power-up memory pass runs once and never restarts.
   `TCCS_ASSERT_NEXT(a_init_once, clock, reset, !init_busy, !init_busy)

endmodule

/* tb/text_console_checker.sv */
module text_console_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  tccs_pkg::req_item_type req_data,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  tccs_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [7:0]             csr_data,
   output int                     mismatch_count,
   output int                     results_pending,
   output int                     results_checked,
   output int                     scroll_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the screen, the cursor and the attribute register.
   logic [15:0]            screen_cells [ROWS*COLUMNS];
   int                     cursor_row;
   int                     cursor_col;
   logic [7:0]             text_attr;
   tccs_pkg::rsp_item_type expected_results [$];

   function automatic void queue_result(logic echo, logic [7:0] ch,
                                        logic [15:0] cell_word, logic last);
      tccs_pkg::rsp_item_type r;
      r.echo_valid     = echo;
      r.echo_char      = ch;
      r.cell_value     = cell_word;
      r.cursor_row_out = 5'(cursor_row);
      r.cursor_col_out = 7'(cursor_col);
      r.last           = last;
      expected_results.push_back(r);
   endfunction

   // Acts on one character exactly as the screen logic does, then queues its echo.
   function automatic void print_char(logic [7:0] c, logic last);
      if (c == tccs_pkg::CHAR_LF) begin
         cursor_row++;
      end else if (c == tccs_pkg::CHAR_CR) begin
         cursor_col = 0;
      end else if (c == tccs_pkg::CHAR_TAB) begin
         cursor_col += tccs_pkg::TAB_STEP;
      end else begin
         if (cursor_row < ROWS && cursor_col < COLUMNS) begin
            screen_cells[cursor_row*COLUMNS + cursor_col] = {text_attr, c};
         end
         cursor_col++;
      end
      if (cursor_col >= COLUMNS) begin
         cursor_col = 0;
         cursor_row++;
      end
      // Reaching the last row shifts everything up; the last row keeps its cells.
      if (cursor_row >= ROWS - 1) begin
         for (int i = 0; i < (ROWS - 1)*COLUMNS; i++) begin
            screen_cells[i] = screen_cells[i + COLUMNS];
         end
         cursor_row--;
         scroll_count++;
      end
      queue_result(1'b1, c, 16'h0000, last);
   endfunction

   function automatic void predict_request(tccs_pkg::req_item_type item);
      logic [3:0]  nibble;
      logic [7:0]  digit;
      logic [15:0] cell_word;
      case (item.cmd)
         tccs_pkg::CMD_PUT_CHAR: begin
            print_char(item.char_code, 1'b1);
         end
         tccs_pkg::CMD_PUT_HEX: begin
            print_char(tccs_pkg::CHAR_ZERO, 1'b0);
            print_char(tccs_pkg::CHAR_X, 1'b0);
            for (int k = 7; k >= 0; k--) begin
               nibble = item.hex_value[4*k +: 4];
               digit  = (nibble <= tccs_pkg::NIBBLE_MAX)
                        ? tccs_pkg::CHAR_ZERO + {4'h0, nibble}
                        : tccs_pkg::CHAR_HEX_A + {4'h0, nibble};
               print_char(digit, k == 0);
            end
         end
         tccs_pkg::CMD_CLEAR: begin
            for (int i = 0; i < ROWS*COLUMNS; i++) begin
               screen_cells[i] = {text_attr, tccs_pkg::CHAR_SPACE};
            end
            cursor_row = 0;
            cursor_col = 0;
            queue_result(1'b0, 8'h00, 16'h0000, 1'b1);
         end
         default: begin
            cell_word = 16'h0000;
            if (item.read_row < ROWS && item.read_col < COLUMNS) begin
               cell_word = screen_cells[item.read_row*COLUMNS + item.read_col];
            end
            queue_result(1'b0, 8'h00, cell_word, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      tccs_pkg::rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < ROWS*COLUMNS; i++) begin
            screen_cells[i] = 16'h0000;
         end
         cursor_row = 0;
         cursor_col = 0;
         text_attr  = tccs_pkg::ATTR_RESET;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            text_attr = csr_data;
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("echo_valid", want.echo_valid, rsp_data.echo_valid);
               check_field("echo_char", want.echo_char, rsp_data.echo_char);
               check_field("cell_value", want.cell_value, rsp_data.cell_value);
               check_field("cursor_row_out", want.cursor_row_out, rsp_data.cursor_row_out);
               check_field("cursor_col_out", want.cursor_col_out, rsp_data.cursor_col_out);
               check_field("last", want.last, rsp_data.last);
               results_checked++;
            end
         end
         if (req_push && !req_full) begin
            predict_request(req_data);
         end
      end
      results_pending = expected_results.size();
   end

endmodule

/* tb/text_console_cursor_scroll_tb.sv */
module text_console_cursor_scroll_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   // A clear or a scroll pushes its result only once it is done, yet each quiet
   // point still waits out one full pass over the screen.
   localparam int SETTLE_CYCLES = ROWS*COLUMNS + 100;

   // Long receiver stall, several scroll passes long, used to fill the block up
   // and make it push back even when a scroll is running when the stall begins.
   localparam int HOLD_OFF_CYCLES = 4*ROWS*COLUMNS;

   localparam int RANDOM_PER_PHASE = 130;

   // Worst case per request is a clear plus a hex word that scrolls, with the
   // receiver stalled on every result; the limit is several times that total.
   localparam longint CYCLE_LIMIT = 6_000_000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   tccs_pkg::req_item_type req_data  = '0;
   logic                   rsp_pop   = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [7:0]             csr_data  = 8'h00;
   logic                   req_full;
   logic                   rsp_empty;
   tccs_pkg::rsp_item_type rsp_data;
   logic                   csr_ready;

   int mismatch_count;
   int results_pending;
   int results_checked;
   int scroll_count;

   // Percent chance per request that the sender leaves a gap, and per cycle
   // that the receiver declines to pop.
   int sender_idle_pct   = 18;
   int receiver_idle_pct = 67;

   // The stimulus raises start_hold_off once; the receiver process then
   // counts its own stall down in hold_left.
   logic start_hold_off = 1'b0;
   int   hold_left      = 0;

   longint cycle_count = 0;
   int     chars_sent, hex_sent, clears_sent, reads_sent, attribute_writes;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cursor_scroll #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   text_console_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .scroll_count    (scroll_count)
   );

   // The receiver side. It changes pop only at the falling edge, so the block
   // and the checker both see a settled value at the rising edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left--;
      end else if (start_hold_off) begin
         start_hold_off = 1'b0;
         hold_left      = HOLD_OFF_CYCLES - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, results_pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic tccs_pkg::req_item_type make_request(logic [1:0] cmd, logic [7:0] ch,
                                                           logic [31:0] hex,
                                                           logic [4:0] row,
                                                           logic [6:0] col);
      tccs_pkg::req_item_type item;
      item.cmd       = cmd;
      item.char_code = ch;
      item.hex_value = hex;
      item.read_row  = row;
      item.read_col  = col;
      return item;
   endfunction

   // Random request. Every field is filled with noise first, so the fields a
   // command does not use are exercised too. Clears are kept rare because each
   // one sends the cursor home, and newlines are frequent so that the cursor
   // reaches the bottom and most later newlines scroll the screen.
   function automatic tccs_pkg::req_item_type random_request();
      tccs_pkg::req_item_type item;
      int                     pick;
      int                     flavor;
      item = make_request(tccs_pkg::CMD_PUT_CHAR, 8'($urandom_range(255)), $urandom,
                          5'($urandom_range(31)), 7'($urandom_range(127)));
      pick = $urandom_range(99);
      if (pick < 1) begin
         item.cmd = tccs_pkg::CMD_CLEAR;
      end else if (pick < 13) begin
         item.cmd = tccs_pkg::CMD_PUT_HEX;
      end else if (pick < 29) begin
         item.cmd = tccs_pkg::CMD_READ;
         // Most reads land on the screen; the rest may fall outside it.
         if ($urandom_range(99) < 85) begin
            item.read_row = 5'($urandom_range(ROWS - 1));
            item.read_col = 7'($urandom_range(COLUMNS - 1));
         end
      end else begin
         flavor = $urandom_range(99);
         if (flavor < 30) begin
            item.char_code = tccs_pkg::CHAR_LF;
         end else if (flavor < 36) begin
            item.char_code = tccs_pkg::CHAR_CR;
         end else if (flavor < 44) begin
            item.char_code = tccs_pkg::CHAR_TAB;
         end else if (flavor < 85) begin
            item.char_code = 8'($urandom_range(8'h20, 8'h7E));
         end
      end
      return item;
   endfunction

   // Offers one request, first leaving a random gap if the sender is idling.
   // Entered at a falling edge and left at a falling edge with push still high,
   // so back-to-back requests keep push high without a glitch.
   task automatic send_request(tccs_pkg::req_item_type item);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      case (item.cmd)
         tccs_pkg::CMD_PUT_CHAR: chars_sent++;
         tccs_pkg::CMD_PUT_HEX:  hex_sent++;
         tccs_pkg::CMD_CLEAR:    clears_sent++;
         default:                reads_sent++;
      endcase
   endtask

   task automatic write_attribute(logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      attribute_writes++;
   endtask

   // Stops offering requests, waits for every expected result, then waits out a
   // further pass over the screen before the next phase.
   task automatic drain();
      req_push <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, int hold_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) begin
            start_hold_off <= 1'b1;
         end
         send_request(random_request());
      end
   endtask

   // Directed opening. After the clear the cursor is at the top left; the
   // characters, the tab and the newline put known cells on row 0, the reads
   // probe them and every kind of out-of-range position, and seven hex words
   // bring the cursor to column 70 so that the third tab runs off the right
   // edge and wraps to the next row.
   task automatic run_directed();
      send_request(make_request(tccs_pkg::CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 5'd31, 7'd127));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, 8'h41, 32'h0, 5'd0, 7'd0)); // 'A'
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, 8'h00, 32'h0, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, 8'hFF, 32'hFFFF_FFFF, 5'd31,
                                7'd127));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_TAB, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_LF, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_CR, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0, 7'd2));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd24, 7'd79));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd25, 7'd0));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd0, 7'd80));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd31, 7'd127));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'h0000_0000, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'hFFFF_FFFF, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'h0123_ABCD, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'h89AB_CDEF, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'h4567_9A0F, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, 32'hA5A5_5A5A, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_HEX, 8'h00, $urandom, 5'd0, 7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_TAB, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_TAB, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CHAR_TAB, 32'h0, 5'd0,
                                7'd0));
      send_request(make_request(tccs_pkg::CMD_READ, 8'h00, 32'h0, 5'd1, 7'd69));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block zeroes its screen after reset and holds full meanwhile.
      @(negedge clock);
      while (req_full) @(negedge clock);

      // Sender idles lightly, receiver heavily: results back up behind pops.
      write_attribute(8'h00);
      run_directed();
      drain();
      write_attribute(8'hFF);
      run_random(RANDOM_PER_PHASE, -1);
      drain();

      // Sender idles heavily, receiver lightly: the block often runs dry.
      sender_idle_pct   = 67;
      receiver_idle_pct = 18;
      write_attribute(8'($urandom_range(1, 254)));
      run_random(RANDOM_PER_PHASE, -1);
      drain();

      // Full speed on both sides, with one long receiver stall part way
      // through so the result side fills and the request side pushes back.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_attribute(8'h1E);
      run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE / 3);
      drain();

      @(negedge clock);
      $display("Sent %0d requests (%0d characters, %0d hex words, %0d clears, %0d reads)",
               chars_sent + hex_sent + clears_sent + reads_sent,
               chars_sent, hex_sent, clears_sent, reads_sent);
      $display("over %0d attribute settings and three stall mixes; %0d results checked, %0d scrolls.",
               attribute_writes, results_checked, scroll_count);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches, %0d expected results never arrived.",
                  mismatch_count, results_pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
